// File: src/aesp_pkg.sv
package aesp_pkg;

	localparam int unsigned ARG_W = 14;
	localparam logic [ARG_W-1:0] ARG_MAX = 14'd9999;

	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	localparam logic [ARG_W-1:0] SGR_RESET  = 14'd0;
	localparam logic [ARG_W-1:0] SGR_FG_LO  = 14'd30;
	localparam logic [ARG_W-1:0] SGR_FG_HI  = 14'd37;
	localparam logic [ARG_W-1:0] SGR_BG_LO  = 14'd40;
	localparam logic [ARG_W-1:0] SGR_BG_HI  = 14'd47;
	localparam logic [ARG_W-1:0] ERASE_MAX  = 14'd2;

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_ARG1 = 2'd2,
		PH_ARG2 = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		CMD_PRINT      = 4'd0,
		CMD_ERASE_BACK = 4'd1,
		CMD_TAB        = 4'd2,
		CMD_NEWLINE    = 4'd3,
		CMD_MOVEBY     = 4'd4,
		CMD_LINEMOVE   = 4'd5,
		CMD_SETCOL     = 4'd6,
		CMD_SETPOS     = 4'd7,
		CMD_CLEAR      = 4'd8,
		CMD_ERASESCR   = 4'd9,
		CMD_ERASELINE  = 4'd10,
		CMD_RESETATTR  = 4'd11,
		CMD_FG         = 4'd12,
		CMD_BG         = 4'd13
	} cmd_t;

	typedef struct packed {
		logic               last_out;
		logic signed [14:0] arg_b;
		logic signed [14:0] arg_a;
		logic [7:0]         char_out;
		cmd_t               command;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} parse_out_t;

	function automatic result_t mk_result(input cmd_t cmd, input logic [7:0] ch,
		input logic signed [14:0] a, input logic signed [14:0] b, input logic last);
		result_t r;
		r.command  = cmd;
		r.char_out = ch;
		r.arg_a    = a;
		r.arg_b    = b;
		r.last_out = last;
		return r;
	endfunction

endpackage

// File: src/aesp_parser.sv
module aesp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            byte_in,
	input  logic                  fire,
	output aesp_pkg::parse_out_t  po
);

	aesp_pkg::phase_t ph_q, ph_d;
	logic [aesp_pkg::ARG_W-1:0] a1_q, a1_d, a2_q, a2_d;
	logic f1p_q, f1p_d, f2p_q, f2p_d;

	logic               digit;
	logic [3:0]         dval;
	logic [aesp_pkg::ARG_W-1:0] p1, p2, z1;
	logic signed [14:0] sp1, sp2, sz1;
	logic               dsp_ok;
	aesp_pkg::result_t  dsp_res;
	aesp_pkg::result_t  nores;

	function automatic logic [aesp_pkg::ARG_W-1:0] acc10(
		input logic [aesp_pkg::ARG_W-1:0] acc, input logic [3:0] d);
		logic [17:0] v;
		v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {14'd0, d};
		if (v > {4'd0, aesp_pkg::ARG_MAX})
			return aesp_pkg::ARG_MAX;
		return v[aesp_pkg::ARG_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= aesp_pkg::PH_TEXT;
			a1_q  <= '0;
			a2_q  <= '0;
			f1p_q <= 1'b0;
			f2p_q <= 1'b0;
		end else if (fire) begin
			ph_q  <= ph_d;
			a1_q  <= a1_d;
			a2_q  <= a2_d;
			f1p_q <= f1p_d;
			f2p_q <= f2p_d;
		end
	end

	assign digit = (byte_in inside {["0":"9"]});
	assign dval  = 4'(byte_in - aesp_pkg::CH_ZERO);
	assign p1    = f1p_q ? a1_q : 14'd1;
	assign p2    = f2p_q ? a2_q : 14'd1;
	assign z1    = f1p_q ? a1_q : 14'd0;
	assign sp1   = $signed({1'b0, p1});
	assign sp2   = $signed({1'b0, p2});
	assign sz1   = $signed({1'b0, z1});
	assign nores = aesp_pkg::mk_result(aesp_pkg::CMD_PRINT, 8'd0, 15'sd0, 15'sd0, 1'b1);

	// CSI final byte
	always_comb begin
		dsp_ok  = 1'b1;
		dsp_res = nores;
		case (byte_in)
			"A": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0, 15'sd0, -sp1, 1'b1);
			"B": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0, 15'sd0, sp1, 1'b1);
			"C": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0, sp1, 15'sd0, 1'b1);
			"D": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0, -sp1, 15'sd0, 1'b1);
			"E": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_LINEMOVE, 8'd0, 15'sd0, sp1, 1'b1);
			"F": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_LINEMOVE, 8'd0, 15'sd0, -sp1, 1'b1);
			"G": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_SETCOL, 8'd0, sp1, 15'sd0, 1'b1);
			"H": dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_SETPOS, 8'd0, sp2, sp1, 1'b1);
			"J": begin
				dsp_ok  = (z1 <= aesp_pkg::ERASE_MAX);
				dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_ERASESCR, 8'd0, sz1, 15'sd0, 1'b1);
			end
			"K": begin
				dsp_ok  = (z1 <= aesp_pkg::ERASE_MAX);
				dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_ERASELINE, 8'd0, sz1, 15'sd0, 1'b1);
			end
			"m": begin
				if (z1 == aesp_pkg::SGR_RESET) begin
					dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_RESETATTR, 8'd0,
						15'sd0, 15'sd0, 1'b1);
				end else if (z1 inside {[aesp_pkg::SGR_FG_LO:aesp_pkg::SGR_FG_HI]}) begin
					dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_FG, 8'd0,
						$signed({1'b0, z1 - aesp_pkg::SGR_FG_LO}), 15'sd0, 1'b1);
				end else if (z1 inside {[aesp_pkg::SGR_BG_LO:aesp_pkg::SGR_BG_HI]}) begin
					dsp_res = aesp_pkg::mk_result(aesp_pkg::CMD_BG, 8'd0,
						$signed({1'b0, z1 - aesp_pkg::SGR_BG_LO}), 15'sd0, 1'b1);
				end else begin
					dsp_ok = 1'b0;
				end
			end
			default: dsp_ok = 1'b0;
		endcase
	end

	always_comb begin
		ph_d      = ph_q;
		a1_d      = a1_q;
		a2_d      = a2_q;
		f1p_d     = f1p_q;
		f2p_d     = f2p_q;
		po.count  = 2'd0;
		po.first  = nores;
		po.second = nores;
		case (ph_q)
			aesp_pkg::PH_ESC: begin
				ph_d = aesp_pkg::PH_TEXT;
				case (byte_in)
					"c": begin
						po.count = 2'd1;
						po.first = aesp_pkg::mk_result(aesp_pkg::CMD_CLEAR, 8'd0,
							15'sd0, 15'sd0, 1'b1);
					end
					"D": begin
						po.count = 2'd1;
						po.first = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0,
							15'sd0, 15'sd1, 1'b1);
					end
					"E": begin
						po.count = 2'd1;
						po.first = aesp_pkg::mk_result(aesp_pkg::CMD_NEWLINE, 8'd0,
							15'sd0, 15'sd0, 1'b1);
					end
					"M": begin
						po.count = 2'd1;
						po.first = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0,
							15'sd0, -15'sd1, 1'b1);
					end
					"[": begin
						ph_d  = aesp_pkg::PH_ARG1;
						a1_d  = '0;
						a2_d  = '0;
						f1p_d = 1'b0;
						f2p_d = 1'b0;
					end
					default: ;
				endcase
			end
			aesp_pkg::PH_ARG1: begin
				if (digit) begin
					f1p_d = 1'b1;
					a1_d  = acc10(a1_q, dval);
				end else if (byte_in == aesp_pkg::CH_SEMI) begin
					f2p_d = 1'b1;
					ph_d  = aesp_pkg::PH_ARG2;
				end else begin
					ph_d     = aesp_pkg::PH_TEXT;
					po.count = {1'b0, dsp_ok};
					po.first = dsp_res;
				end
			end
			aesp_pkg::PH_ARG2: begin
				if (digit) begin
					a2_d = acc10(a2_q, dval);
				end else begin
					ph_d     = aesp_pkg::PH_TEXT;
					po.count = {1'b0, dsp_ok};
					po.first = dsp_res;
				end
			end
			default: begin
				if (byte_in >= aesp_pkg::CH_SPACE && byte_in != aesp_pkg::CH_DEL) begin
					po.count = 2'd1;
					po.first = aesp_pkg::mk_result(aesp_pkg::CMD_PRINT, byte_in,
						15'sd0, 15'sd0, 1'b1);
				end else begin
					case (byte_in)
						aesp_pkg::CH_BEL, aesp_pkg::CH_DEL: ;
						aesp_pkg::CH_BS: begin
							po.count = 2'd1;
							po.first = aesp_pkg::mk_result(aesp_pkg::CMD_ERASE_BACK, 8'd0,
								15'sd0, 15'sd0, 1'b1);
						end
						aesp_pkg::CH_TAB: begin
							po.count = 2'd1;
							po.first = aesp_pkg::mk_result(aesp_pkg::CMD_TAB, 8'd0,
								15'sd0, 15'sd0, 1'b1);
						end
						aesp_pkg::CH_LF: begin
							po.count = 2'd1;
							po.first = aesp_pkg::mk_result(aesp_pkg::CMD_NEWLINE, 8'd0,
								15'sd0, 15'sd0, 1'b1);
						end
						aesp_pkg::CH_VT, aesp_pkg::CH_FF: begin
							po.count = 2'd1;
							po.first = aesp_pkg::mk_result(aesp_pkg::CMD_MOVEBY, 8'd0,
								15'sd0, 15'sd1, 1'b1);
						end
						aesp_pkg::CH_CR: begin
							po.count = 2'd1;
							po.first = aesp_pkg::mk_result(aesp_pkg::CMD_SETCOL, 8'd0,
								15'sd0, 15'sd0, 1'b1);
						end
						aesp_pkg::CH_ESC: ph_d = aesp_pkg::PH_ESC;
						default: begin
							// caret notation
							po.count  = 2'd2;
							po.first  = aesp_pkg::mk_result(aesp_pkg::CMD_PRINT,
								aesp_pkg::CH_CARET, 15'sd0, 15'sd0, 1'b0);
							po.second = aesp_pkg::mk_result(aesp_pkg::CMD_PRINT,
								aesp_pkg::CH_AT + byte_in, 15'sd0, 15'sd0, 1'b1);
						end
					endcase
				end
			end
		endcase
	end

endmodule

// File: src/ansi_escape_sequence_parser.sv
// Terminal byte stream to screen command parser.
// Input channel s_axis: one terminal byte per word in tdata[7:0].
// Output channel m_axis: one screen command per word; tlast marks the last
// command caused by an input byte. Most bytes give zero or one command;
// control bytes shown in caret notation give two.
// A byte is first registered in the input register (byte_s1); its command is
// then registered in out_q and offered on m_axis.
// Throughput: one byte per cycle while the receiver keeps up; a caret byte
// gives two commands, which leave one after the other through the single output port.
// Bytes that give no command (digits and separators inside a CSI sequence,
// ESC, BEL, DEL) pass even while a command waits at the output.
// Reset puts the parser in normal text mode with empty arguments and
// drops any buffered byte or command.
// When the receiver holds tready low, the pending command holds steady and
// input stalls once the input register holds a byte that needs output room.
module ansi_escape_sequence_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [3:0] command, [11:4] char_out,
	                                   // [26:12] arg_a, [41:27] arg_b, rest zero
	output logic        m_axis_tlast   // last_out
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 fire;
	logic                 space;
	aesp_pkg::parse_out_t po;

	logic                 out_valid_q;
	aesp_pkg::result_t    out_q;
	logic                 pend_valid_q;
	aesp_pkg::result_t    pend_q;

	aesp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.fire    (fire),
		.po      (po)
	);

	assign space         = !pend_valid_q && (!out_valid_q || m_axis_tready);
	assign fire          = valid_s1 && ((po.count == 2'd0) || space);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			byte_s1 <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q && m_axis_tready) begin
			pend_valid_q <= 1'b0;
		end else if (fire && po.count != 2'd0) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= (po.count == 2'd2);
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && m_axis_tready) begin
			out_q <= pend_q;
		end else if (fire && po.count != 2'd0) begin
			out_q  <= po.first;
			pend_q <= po.second;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.arg_b, out_q.arg_a, out_q.char_out,
		out_q.command};
	assign m_axis_tlast  = out_q.last_out;

endmodule
